/* design/swm_pkg.sv */
// Package for the sliding window mean unit.
// Holds the sample type and the fixed constants of the window length rule.
// No dependencies.
`default_nettype none

package swm_pkg;

    // Sample and mean format: signed, 24 fraction bits
    localparam int SAMPLE_W        = 32;
    // Window register width and its value after reset
    localparam int YEARS_W         = 6;
    localparam int YEARS_RESET     = 10;
    // Samples per year, and the width of twelve times the largest year count
    localparam int MONTHS_PER_YEAR = 12;
    localparam int RAW_LEN_W       = 10;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

endpackage

`default_nettype wire

/* design/sliding_window_mean_unit.sv */
// Sliding window mean unit: simple moving average of a stream of rate samples.
//
// Input stream (s_axis): tdata carries one signed sample with 24 fraction bits,
// tuser marks the first sample of a path, tlast marks the last one. An item is
// taken when tvalid and tready are both high.
// Output stream (m_axis): tdata carries the mean of the last L samples,
// L = 12 * window_years (zero counts as one, capped at MAX_WINDOW), truncated
// toward zero. A result appears only once L samples of the path are held, and
// never for a sample marked last.
// Configuration: i_cfg_we writes window_years from i_cfg_wdata; the write also
// restarts the window. Write only while the unit is idle.
// Sequence: an item that gives no result passes the update state and returns to
// idle. An item that gives a result then enters the bit-serial divider, which
// forms one quotient bit per cycle; the mean is loaded into the output register
// and appears on m_axis once the divider is done and the output register is free.
// The output register lets the next item be taken while a mean waits; a stalled
// receiver holds the following mean in the divider and then stops the input.
// Reset (synchronous, active low) empties the window and sets window_years to 10;
// the sample memory needs no clearing, only entries written since the last
// path start are ever read.
// Depends on swm_pkg, swm_ram and swm_div.
`default_nettype none

module sliding_window_mean_unit
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW = 512
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Input stream
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic signed [31:0]  s_axis_tdata,   // [31:0] rate_sample
    input  wire logic                s_axis_tuser,   // [0] path_start
    input  wire logic                s_axis_tlast,   // path_end
    // Output stream
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic signed [31:0]       m_axis_tdata,   // [31:0] window_mean
    // Configuration
    input  wire logic                i_cfg_we,
    input  wire logic [5:0]          i_cfg_wdata     // window_years
);

    localparam int PTR_W  = $clog2(MAX_WINDOW);
    localparam int ADR_W  = PTR_W + 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_W + PTR_W;
    localparam int LCMP_W = (CNT_W > RAW_LEN_W) ? CNT_W : RAW_LEN_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    // Window length from the year count: zero acts as one, capped at MAX_WINDOW
    function automatic logic [CNT_W-1:0] win_len(input logic [YEARS_W-1:0] years);
        logic [YEARS_W-1:0]   y;
        logic [RAW_LEN_W-1:0] raw;
        logic [LCMP_W-1:0]    raw_ext;
        y       = (years == '0) ? YEARS_W'(1) : years;
        raw     = RAW_LEN_W'(y) * RAW_LEN_W'(MONTHS_PER_YEAR);
        raw_ext = LCMP_W'(raw);
        if (raw_ext > LCMP_W'(MAX_WINDOW)) begin
            return CNT_W'(MAX_WINDOW);
        end
        return raw_ext[CNT_W-1:0];
    endfunction

    logic [1:0]              r_state;
    logic [1:0]              n_state;
    logic [CNT_W-1:0]        r_len;
    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]        r_seen;
    logic [PTR_W-1:0]        r_wp;
    logic                    r_sub;
    logic                    r_emit;
    logic                    r_out_valid;
    t_sample                 r_out_data;

    logic                    in_acc;
    logic [CNT_W-1:0]        seen_eff;
    logic [CNT_W-1:0]        seen_new;
    logic signed [SUM_W-1:0] sum_eff;
    logic signed [SUM_W-1:0] sum_upd;
    logic signed [SUM_W-1:0] x_ext;
    logic signed [SUM_W-1:0] old_ext;
    logic [ADR_W-1:0]        wp_ext;
    logic [ADR_W-1:0]        len_ext;
    logic [ADR_W-1:0]        old_addr;
    logic [SAMPLE_W-1:0]     ram_rdata;
    logic                    div_start;
    logic                    div_busy;
    logic                    div_done;
    logic                    div_take;
    t_sample                 div_quo;
    logic                    out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Path start empties the window before the marked sample goes in
    assign seen_eff = s_axis_tuser ? '0 : r_seen;
    assign sum_eff  = s_axis_tuser ? '0 : r_sum;
    assign seen_new = (seen_eff == CNT_W'(MAX_WINDOW)) ? seen_eff : seen_eff + CNT_W'(1);
    assign x_ext    = {{(SUM_W-SAMPLE_W){s_axis_tdata[SAMPLE_W-1]}}, s_axis_tdata};
    assign old_ext  = {{(SUM_W-SAMPLE_W){ram_rdata[SAMPLE_W-1]}}, ram_rdata};

    // Sum with the leaving sample removed; feeds both the register and the divider
    assign sum_upd  = r_sub ? (r_sum - old_ext) : r_sum;

    // Address of the sample that leaves the window, L entries behind the pointer
    assign wp_ext   = ADR_W'(r_wp);
    assign len_ext  = ADR_W'(r_len);
    assign old_addr = (wp_ext >= len_ext) ? (wp_ext - len_ext)
                                          : (wp_ext + ADR_W'(MAX_WINDOW) - len_ext);

    // Sample memory: write the new sample, read the leaving one in the same cycle
    swm_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(MAX_WINDOW)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (in_acc),
        .i_waddr(r_wp),
        .i_wdata(s_axis_tdata),
        .i_raddr(old_addr[PTR_W-1:0]),
        .o_rdata(ram_rdata)
    );

    assign out_free  = !r_out_valid || m_axis_tready;
    assign div_start = (r_state == S_UPD) && r_emit;
    assign div_take  = (r_state == S_DIV) && div_done && out_free;

    swm_div #(
        .SUM_W(SUM_W),
        .DIV_W(CNT_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(sum_upd),
        .i_divisor (r_len),
        .i_take    (div_take),
        .o_busy    (div_busy),
        .o_done    (div_done),
        .o_quotient(div_quo)
    );

    // Sequencer: take item, fold in the leaving sample, then divide if a mean is due
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = r_emit ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (div_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Window state: length, running sum, fill count, write pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= win_len(YEARS_W'(YEARS_RESET));
            r_sum   <= '0;
            r_seen  <= '0;
            r_wp    <= '0;
            r_sub   <= 1'b0;
            r_emit  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_len  <= win_len(i_cfg_wdata);
                r_sum  <= '0;
                r_seen <= '0;
            end else if (in_acc) begin
                r_sum  <= sum_eff + x_ext;
                r_seen <= seen_new;
                r_wp   <= (r_wp == PTR_W'(MAX_WINDOW - 1)) ? '0 : r_wp + PTR_W'(1);
                r_sub  <= (seen_eff >= r_len);
                r_emit <= (seen_new >= r_len) && !s_axis_tlast;
            end else if (r_state == S_UPD) begin
                r_sum <= sum_upd;
            end
        end
    end

    // Output register: load a finished mean, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (div_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_take) begin
            r_out_data <= div_quo;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTH
    // The divider never runs while the input side is open
    a_ready_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !div_busy)
        else $error("input ready while divider busy");

    // Fill count stays within the memory depth
    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= CNT_W'(MAX_WINDOW))
        else $error("fill count beyond window depth");

    // Window length stays between one year and the memory depth
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len >= CNT_W'(MONTHS_PER_YEAR)) && (r_len <= CNT_W'(MAX_WINDOW)))
        else $error("window length out of range");

    // A taken item is folded in on the next cycle
    a_acc_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_UPD))
        else $error("accepted item not followed by update");

    // A held quotient only exists while the sequencer waits for it
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider result outside divide state");
`endif

endmodule

`default_nettype wire

/* design/swm_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Read-first: a read of the address written in the same cycle returns the old data.
// No dependencies.
`default_nettype none

module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and read in one process so the read sees the old contents
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* design/swm_div.sv */
// Bit-serial signed divider for the window mean: sum / length, truncated toward zero.
// One quotient bit per cycle on the magnitude of the sum; result held until taken.
// Depends on swm_pkg.
`default_nettype none

module swm_div
    import swm_pkg::*;
#(
    parameter int SUM_W = 41,
    parameter int DIV_W = 10
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [SUM_W-1:0] i_dividend,
    input  wire logic [DIV_W-1:0]        i_divisor,
    input  wire logic                    i_take,
    output logic                         o_busy,
    output logic                         o_done,
    output t_sample                      o_quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [SUM_W-1:0] r_quo;
    logic [DIV_W-1:0] r_div;
    logic             r_neg;

    logic [DIV_W:0]          rem_sh;
    logic [DIV_W:0]          rem_diff;
    logic                    rem_ge;
    logic [SUM_W-1:0]        dividend_mag;
    logic [SAMPLE_W-1:0]     quo_mag;

    // Magnitude of the dividend
    assign dividend_mag = i_dividend[SUM_W-1] ? (~i_dividend + SUM_W'(1)) : i_dividend;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_sh   = {r_rem, r_quo[SUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_div};
    assign rem_ge   = (rem_sh >= {1'b0, r_div});

    // Control: load on start, count down the steps, hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start && !r_busy) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(SUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else if (i_take) begin
            r_done <= 1'b0;
        end
    end

    // Datapath: remainder and the shift register that turns dividend into quotient
    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_quo <= dividend_mag;
            r_div <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_busy) begin
            r_rem <= rem_ge ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], rem_ge};
        end
    end

    // Apply the sign; the magnitude never exceeds two to the 31
    assign quo_mag    = r_quo[SAMPLE_W-1:0];
    assign o_quotient = r_neg ? t_sample'(~quo_mag + SAMPLE_W'(1)) : t_sample'(quo_mag);
    assign o_busy     = r_busy;
    assign o_done     = r_done;

endmodule

`default_nettype wire
